// File: rtl/hbsp_pkg.sv
// Shared types and constants of the hex or BCD string packer.
`default_nettype none

package hbsp_pkg;

   // Character codes the packer looks for.
   localparam logic [7:0] CHAR_0       = 8'h30;
   localparam logic [7:0] CHAR_9       = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;

   // Configuration register indexes.
   localparam logic CSR_DIGIT_MODE = 1'b0;
   localparam logic CSR_CAPACITY   = 1'b1;

   localparam logic [15:0] CAPACITY_RESET = 16'h8000;

   // Digit modes.
   localparam logic MODE_HEX = 1'b0;
   localparam logic MODE_DEC = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_CAPACITY = 2'd1,
      STAT_TOO_LONG = 2'd2
   } status_type;

   // Classification of one character.
   typedef struct packed {
      logic       is_digit;
      logic [3:0] value;
      logic       is_x;
   } digit_type;

   // One result item.
   typedef struct packed {
      logic [15:0] byte_count;
      status_type  status;
      logic        done_res;
      logic        out_valid;
      logic [7:0]  out_byte;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/hbsp_digit_dec.sv
// Character classifier: digit value in the selected mode and prefix letter detect.
`default_nettype none

module hbsp_digit_dec
   import hbsp_pkg::*;
(
   input  wire logic      digit_mode,
   input  wire logic [7:0] ch,
   output digit_type      digit
);

   logic       is_dec;
   logic       is_upper;
   logic       is_lower;
   logic [7:0] diff;

   always_comb begin
      is_dec   = (ch >= CHAR_0) && (ch <= CHAR_9);
      is_upper = (digit_mode == MODE_HEX) && (ch >= CHAR_UPPER_A) && (ch <= CHAR_UPPER_F);
      is_lower = (digit_mode == MODE_HEX) && (ch >= CHAR_LOWER_A) && (ch <= CHAR_LOWER_F);
      diff     = 8'h00;
      if (is_dec) begin
         diff = ch - CHAR_0;
      end else if (is_upper) begin
         diff = ch - CHAR_UPPER_A + 8'd10;
      end else if (is_lower) begin
         diff = ch - CHAR_LOWER_A + 8'd10;
      end
      digit.is_digit = is_dec || is_upper || is_lower;
      digit.value    = diff[3:0];
      digit.is_x     = (ch == CHAR_LOWER_X) || (ch == CHAR_UPPER_X);
   end

endmodule

`default_nettype wire

// File: rtl/hbsp_pack_core.sv
// Per-string packing state and the single-pass next-state and result logic.
`default_nettype none

module hbsp_pack_core
   import hbsp_pkg::*;
#(
   parameter int MAX_CHARS = 65536
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic [15:0] capacity,
   input  wire digit_type   digit,
   input  wire logic        first,
   input  wire logic        odd_length,
   input  wire logic        last,
   output result_type       result
);

   localparam int CHARS_W = $clog2(MAX_CHARS + 2);
   localparam logic [CHARS_W-1:0] MAX_CHARS_C = CHARS_W'(MAX_CHARS);

   logic               pend_valid_ff, pend_valid_in;
   logic [3:0]         pend_nibble_ff, pend_nibble_in;
   logic [15:0]        bytes_out_ff, bytes_out_in;
   logic [CHARS_W-1:0] chars_seen_ff, chars_seen_in;
   status_type         error_ff, error_in;

   logic               pv_base;
   logic [3:0]         pn_base;
   logic [15:0]        bo_base;
   logic [CHARS_W-1:0] cs_base;
   status_type         err_base;
   logic               emit_req;
   logic [7:0]         emit_byte;

   always_comb begin
      // A new string starts from clean counts; an odd length preloads a '0'.
      pv_base  = first ? odd_length : pend_valid_ff;
      pn_base  = first ? 4'h0 : pend_nibble_ff;
      bo_base  = first ? 16'h0000 : bytes_out_ff;
      cs_base  = first ? CHARS_W'(odd_length) : chars_seen_ff;
      err_base = first ? STAT_OK : error_ff;

      chars_seen_in = (cs_base <= MAX_CHARS_C) ? cs_base + 1'b1 : cs_base;
      error_in      = err_base;
      if ((chars_seen_in > MAX_CHARS_C) && (err_base == STAT_OK)) begin
         error_in = STAT_TOO_LONG;
      end

      pend_valid_in  = 1'b0;
      pend_nibble_in = 4'h0;
      emit_req       = 1'b0;
      emit_byte      = 8'h00;
      if (error_in == STAT_OK) begin
         if (pv_base) begin
            // A pending high digit followed by x is treated as a 0x prefix and dropped, whatever its value.
            if (!digit.is_x) begin
               emit_req  = 1'b1;
               emit_byte = digit.is_digit ? {pn_base, digit.value} : {4'h0, pn_base};
            end
         end else if (digit.is_digit) begin
            if (last) begin
               emit_req  = 1'b1;
               emit_byte = {4'h0, digit.value};
            end else begin
               pend_valid_in  = 1'b1;
               pend_nibble_in = digit.value;
            end
         end
      end

      bytes_out_in     = bo_base;
      result.out_valid = 1'b0;
      result.out_byte  = 8'h00;
      if (emit_req) begin
         if (bo_base >= capacity) begin
            error_in = STAT_CAPACITY;
         end else begin
            result.out_valid = 1'b1;
            result.out_byte  = emit_byte;
            bytes_out_in     = bo_base + 16'd1;
         end
      end

      if (last) begin
         pend_valid_in  = 1'b0;
         pend_nibble_in = 4'h0;
      end

      result.done_res   = last;
      result.status     = error_in;
      result.byte_count = bytes_out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff  <= 1'b0;
         pend_nibble_ff <= 4'h0;
         bytes_out_ff   <= 16'h0000;
         chars_seen_ff  <= '0;
         error_ff       <= STAT_OK;
      end else if (step) begin
         pend_valid_ff  <= pend_valid_in;
         pend_nibble_ff <= pend_nibble_in;
         bytes_out_ff   <= bytes_out_in;
         chars_seen_ff  <= chars_seen_in;
         error_ff       <= error_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/hex_or_bcd_string_packer_core.sv
// Top level of the hex or BCD string packer: channels, registers and stages.
//
// Usage: a string is sent one ASCII character per transfer on the req_ channel,
// with req_tuser[0] marking its first character, req_tuser[1] saying the string
// has odd length (read with the first character) and req_tlast its final one.
// Every input transfer gives exactly one rsp_ transfer: the packed byte and a
// flag saying whether a byte was produced, the running byte count, a sticky
// status (capacity exceeded or string too long) and tlast copied from the input.
// The csr_ port writes the digit mode (hex or decimal) and the byte capacity;
// the user must write it only while the block is idle; the block does not enforce this.
// A character lands in the input register on its transfer; the packing logic
// then updates the string state and loads the result register once that
// register is free. Throughput is one character per clock while the receiver
// does not stall, set by the update of the pending nibble and counters.
// When the receiver stalls, the result register holds and the input register
// still takes one more character; after that req_tready drops until rsp_tready
// returns. Reset clears both valid flags and the string state, and sets the
// digit mode to hex and the capacity to 32768 bytes.
`default_nettype none

module hex_or_bcd_string_packer_core
   import hbsp_pkg::*;
#(
   parameter int MAX_CHARS = 65536
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Input character channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] ch
   input  wire logic [1:0]  req_tuser,   // [0] first, [1] odd_length
   input  wire logic        req_tlast,   // last
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] out_byte, [23:8] byte_count
   output logic [2:0]       rsp_tuser,   // [0] out_valid, [2:1] status
   output logic             rsp_tlast,   // done_res
   // Configuration write port.
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   logic        digit_mode_ff;
   logic [15:0] capacity_ff;

   logic        in_valid_ff;
   logic [7:0]  in_ch_ff;
   logic        in_first_ff;
   logic        in_odd_ff;
   logic        in_last_ff;

   logic        out_valid_ff;
   result_type  out_ff;

   logic        out_free;
   logic        step;
   digit_type   digit;
   result_type  result;

   // The result register can load when it is empty or being drained.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_mode_ff <= MODE_HEX;
         capacity_ff   <= CAPACITY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DIGIT_MODE: digit_mode_ff <= csr_wdata[0];
            CSR_CAPACITY:   capacity_ff   <= csr_wdata;
            default:        ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ch_ff    <= req_tdata;
         in_first_ff <= req_tuser[0];
         in_odd_ff   <= req_tuser[1];
         in_last_ff  <= req_tlast;
      end
   end

   hbsp_digit_dec u_digit_dec (
      .digit_mode (digit_mode_ff),
      .ch         (in_ch_ff),
      .digit      (digit)
   );

   hbsp_pack_core #(
      .MAX_CHARS (MAX_CHARS)
   ) u_pack_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .capacity   (capacity_ff),
      .digit      (digit),
      .first      (in_first_ff),
      .odd_length (in_odd_ff),
      .last       (in_last_ff),
      .result     (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.byte_count, out_ff.out_byte};
   assign rsp_tuser  = {out_ff.status, out_ff.out_valid};
   assign rsp_tlast  = out_ff.done_res;

endmodule

`default_nettype wire

// File: rtl/hbsp_chk.sv
// Port-level checker for the packer top level, bound to it.
`default_nettype none

module hbsp_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // Nothing is shown on the result channel right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result keeps its contents.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // A result without a byte carries a zero byte.
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[7:0] == 8'h00)
      else $error("byte field not zero without a byte");

   // A byte is never sent together with an error status.
   a_no_byte_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[2:1] == 2'd0)
      else $error("byte sent with error status");

   // A produced byte is always counted.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[23:8] != 16'h0000)
      else $error("byte sent with zero count");

endmodule

bind hex_or_bcd_string_packer_core hbsp_chk u_hbsp_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
